// ===== hw/rtl/sts_pkg.sv =====
`timescale 1ns / 1ps

package sts_pkg;

   // Fixed field widths of one token on the result channel
   localparam int KIND_W  = 6;
   localparam int START_W = 20;
   localparam int LEN_W   = 21;
   localparam int LINE_W  = 20;
   localparam int MAX_TOK = 3;
   localparam int CNT_W   = 2;
   localparam int TOK_W   = KIND_W + START_W + LEN_W + LINE_W;
   localparam int RSP_DATA_W = ((TOK_W + 7) / 8) * 8;

   // Token kinds
   localparam logic [KIND_W-1:0] K_END       = 6'd0;
   localparam logic [KIND_W-1:0] K_WORD      = 6'd1;
   localparam logic [KIND_W-1:0] K_NUMBER    = 6'd2;
   localparam logic [KIND_W-1:0] K_LPAREN    = 6'd3;
   localparam logic [KIND_W-1:0] K_RPAREN    = 6'd4;
   localparam logic [KIND_W-1:0] K_LBRACE    = 6'd5;
   localparam logic [KIND_W-1:0] K_RBRACE    = 6'd6;
   localparam logic [KIND_W-1:0] K_SEMI      = 6'd7;
   localparam logic [KIND_W-1:0] K_COLON     = 6'd8;
   localparam logic [KIND_W-1:0] K_COMMA     = 6'd9;
   localparam logic [KIND_W-1:0] K_DOT       = 6'd10;
   localparam logic [KIND_W-1:0] K_MINUS_EQ  = 6'd11;
   localparam logic [KIND_W-1:0] K_MINUS     = 6'd12;
   localparam logic [KIND_W-1:0] K_PLUS_EQ   = 6'd13;
   localparam logic [KIND_W-1:0] K_PLUS      = 6'd14;
   localparam logic [KIND_W-1:0] K_SLASH_EQ  = 6'd15;
   localparam logic [KIND_W-1:0] K_SLASH     = 6'd16;
   localparam logic [KIND_W-1:0] K_STAR_EQ   = 6'd17;
   localparam logic [KIND_W-1:0] K_STAR      = 6'd18;
   localparam logic [KIND_W-1:0] K_PCT_EQ    = 6'd19;
   localparam logic [KIND_W-1:0] K_PCT       = 6'd20;
   localparam logic [KIND_W-1:0] K_AMP       = 6'd21;
   localparam logic [KIND_W-1:0] K_PIPE      = 6'd22;
   localparam logic [KIND_W-1:0] K_CARET     = 6'd23;
   localparam logic [KIND_W-1:0] K_TILDE     = 6'd24;
   localparam logic [KIND_W-1:0] K_BANG_EQ   = 6'd25;
   localparam logic [KIND_W-1:0] K_BANG      = 6'd26;
   localparam logic [KIND_W-1:0] K_EQ_EQ     = 6'd27;
   localparam logic [KIND_W-1:0] K_ASSIGN    = 6'd28;
   localparam logic [KIND_W-1:0] K_SHL       = 6'd29;
   localparam logic [KIND_W-1:0] K_LESS_EQ   = 6'd30;
   localparam logic [KIND_W-1:0] K_LESS      = 6'd31;
   localparam logic [KIND_W-1:0] K_SHR       = 6'd32;
   localparam logic [KIND_W-1:0] K_GREATER_EQ = 6'd33;
   localparam logic [KIND_W-1:0] K_GREATER   = 6'd34;
   localparam logic [KIND_W-1:0] K_ERROR     = 6'd35;

   // Characters with a special role in the scan
   localparam logic [7:0] CH_UNDER = 8'h5F; // '_'
   localparam logic [7:0] CH_X     = 8'h78; // 'x'
   localparam logic [7:0] CH_B     = 8'h62; // 'b'
   localparam logic [7:0] CH_O     = 8'h6F; // 'o'
   localparam logic [7:0] CH_E     = 8'h65; // 'e'
   localparam logic [7:0] CH_DASH  = 8'h2D; // '-'
   localparam logic [7:0] CH_LBRK  = 8'h5B; // '['
   localparam logic [7:0] CH_RBRK  = 8'h5D; // ']'
   localparam logic [7:0] CH_EQ    = 8'h3D; // '='
   localparam logic [7:0] CH_LT    = 8'h3C; // '<'
   localparam logic [7:0] CH_GT    = 8'h3E; // '>'
   localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef struct packed {
      logic [LINE_W-1:0]  line;
      logic [LEN_W-1:0]   length;
      logic [START_W-1:0] start;
      logic [KIND_W-1:0]  kind;
   } tok_type;

   // Tokens caused by one input transaction, slot 0 first
   typedef struct packed {
      logic [CNT_W-1:0]           cnt;
      tok_type [MAX_TOK-1:0]      tok;
   } bundle_type;

endpackage

// ===== hw/rtl/sts_core.sv =====
`timescale 1ns / 1ps

module sts_core #(
   parameter longint unsigned MAX_SOURCE_BYTES = 64'd1048576,
   parameter longint unsigned MAX_LINES        = 64'd1048575
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               op,
   input  logic [7:0]         char_byte,
   output sts_pkg::bundle_type bundle
);
   import sts_pkg::*;

   localparam int OFS_W = $clog2(MAX_SOURCE_BYTES + 64'd1);
   localparam int LCW   = $clog2(MAX_LINES + 64'd1);
   localparam logic [OFS_W-1:0] OFS_MAX  = OFS_W'(MAX_SOURCE_BYTES);
   localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(MAX_SOURCE_BYTES - 64'd1);
   localparam logic [LCW-1:0]   LINE_MAX = LCW'(MAX_LINES);

   typedef enum logic [4:0] {
      M_IDLE, M_WORD, M_ZERO, M_DEC, M_DOT, M_FRAC, M_EXPS, M_EXP,
      M_HEX, M_BIN, M_OCT, M_MINUS, M_DASH2, M_DASHBR, M_LINECMT,
      M_BLOCK, M_BLOCKBR, M_PLUS, M_SLASH, M_STAR, M_PCT, M_BANG,
      M_EQ, M_LESS, M_GREATER
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [OFS_W-1:0] ofs_ff, ofs_in;
   logic [OFS_W-1:0] beg_ff, beg_in;
   logic [OFS_W-1:0] dot_ff, dot_in;
   logic [LCW-1:0]   line_ff, line_in;

   bundle_type       bun;
   logic [CNT_W-1:0] n;
   logic             consumed;
   logic             bump;
   logic             pend_mode;
   logic [7:0]       pc2;
   logic [KIND_W-1:0] kd, ke, ka;
   logic [7:0]       c;

   function automatic logic is_dig(input logic [7:0] x);
      return x >= 8'h30 && x <= 8'h39;
   endfunction

   function automatic logic is_let(input logic [7:0] x);
      return (x >= 8'h61 && x <= 8'h7A) || (x >= 8'h41 && x <= 8'h5A);
   endfunction

   function automatic logic is_hexd(input logic [7:0] x);
      return is_dig(x) || (x >= 8'h61 && x <= 8'h66) || (x >= 8'h41 && x <= 8'h46);
   endfunction

   // Build one token; start clips to the last valid offset
   function automatic tok_type mk(input logic [KIND_W-1:0] k,
                                  input logic [OFS_W-1:0] st,
                                  input logic [OFS_W-1:0] len,
                                  input logic [LCW-1:0] ln);
      tok_type t;
      logic [OFS_W-1:0] stc;
      stc      = (st > OFS_LAST) ? OFS_LAST : st;
      t.kind   = k;
      t.start  = START_W'(stc);
      t.length = LEN_W'(len);
      t.line   = LINE_W'(ln);
      return t;
   endfunction

   assign c = char_byte;

   // Held one-char punctuator: second char, kind doubled, kind with '=', kind alone
   always_comb begin
      pend_mode = 1'b1;
      pc2 = CH_EQ;
      kd  = K_PLUS_EQ;
      ke  = K_PLUS_EQ;
      ka  = K_PLUS;
      unique case (mode_ff)
         M_PLUS:    begin kd = K_PLUS_EQ;  ke = K_PLUS_EQ;  ka = K_PLUS;  end
         M_SLASH:   begin kd = K_SLASH_EQ; ke = K_SLASH_EQ; ka = K_SLASH; end
         M_STAR:    begin kd = K_STAR_EQ;  ke = K_STAR_EQ;  ka = K_STAR;  end
         M_PCT:     begin kd = K_PCT_EQ;   ke = K_PCT_EQ;   ka = K_PCT;   end
         M_BANG:    begin kd = K_BANG_EQ;  ke = K_BANG_EQ;  ka = K_BANG;  end
         M_EQ:      begin kd = K_EQ_EQ;    ke = K_EQ_EQ;    ka = K_ASSIGN; end
         M_LESS:    begin pc2 = CH_LT; kd = K_SHL; ke = K_LESS_EQ; ka = K_LESS; end
         M_GREATER: begin pc2 = CH_GT; kd = K_SHR; ke = K_GREATER_EQ; ka = K_GREATER; end
         default:   pend_mode = 1'b0;
      endcase
   end

   // Next scan state and the tokens of this transaction
   always_comb begin
      mode_in  = mode_ff;
      ofs_in   = ofs_ff;
      beg_in   = beg_ff;
      dot_in   = dot_ff;
      line_in  = line_ff;
      bun      = '0;
      n        = '0;
      consumed = 1'b0;
      bump     = 1'b0;

      if (op) begin
         // end of source: flush the open token, then the end token
         if (mode_ff == M_WORD) begin
            bun.tok[n] = mk(K_WORD, beg_ff, ofs_ff - beg_ff, line_ff);
            n = n + 2'd1;
         end else if (mode_ff == M_DOT) begin
            bun.tok[n] = mk(K_NUMBER, beg_ff, dot_ff - beg_ff, line_ff);
            n = n + 2'd1;
            bun.tok[n] = mk(K_DOT, dot_ff, OFS_W'(1), line_ff);
            n = n + 2'd1;
         end else if (mode_ff >= M_ZERO && mode_ff <= M_OCT) begin
            bun.tok[n] = mk(K_NUMBER, beg_ff, ofs_ff - beg_ff, line_ff);
            n = n + 2'd1;
         end else if (mode_ff == M_MINUS) begin
            bun.tok[n] = mk(K_MINUS, beg_ff, OFS_W'(1), line_ff);
            n = n + 2'd1;
         end else if (pend_mode) begin
            bun.tok[n] = mk(ka, beg_ff, OFS_W'(1), line_ff);
            n = n + 2'd1;
         end
         bun.tok[n] = mk(K_END, ofs_ff, '0, line_ff);
         n = n + 2'd1;
         mode_in = M_IDLE;
         ofs_in  = '0;
         beg_in  = '0;
         dot_in  = '0;
         line_in = LCW'(1);
      end else begin
         // continue the open token
         unique case (mode_ff)
            M_WORD: begin
               if (is_let(c) || is_dig(c) || c == CH_UNDER) consumed = 1'b1;
               else begin
                  bun.tok[n] = mk(K_WORD, beg_ff, ofs_ff - beg_ff, line_ff);
                  n = n + 2'd1;
               end
            end
            M_ZERO, M_DEC: begin
               if (mode_ff == M_ZERO && (c == CH_X || c == 8'h58)) begin
                  mode_in = M_HEX; consumed = 1'b1;
               end else if (mode_ff == M_ZERO && (c == CH_B || c == 8'h42)) begin
                  mode_in = M_BIN; consumed = 1'b1;
               end else if (mode_ff == M_ZERO && (c == CH_O || c == 8'h4F)) begin
                  mode_in = M_OCT; consumed = 1'b1;
               end else if (is_dig(c) || c == CH_UNDER) begin
                  mode_in = M_DEC; consumed = 1'b1;
               end else if (c == CH_DOT) begin
                  dot_in = ofs_ff; mode_in = M_DOT; consumed = 1'b1;
               end else if (c == CH_E || c == 8'h45) begin
                  mode_in = M_EXPS; consumed = 1'b1;
               end else begin
                  bun.tok[n] = mk(K_NUMBER, beg_ff, ofs_ff - beg_ff, line_ff);
                  n = n + 2'd1;
               end
            end
            M_DOT: begin
               if (is_dig(c)) begin
                  mode_in = M_FRAC; consumed = 1'b1;
               end else begin
                  bun.tok[n] = mk(K_NUMBER, beg_ff, dot_ff - beg_ff, line_ff);
                  n = n + 2'd1;
                  bun.tok[n] = mk(K_DOT, dot_ff, OFS_W'(1), line_ff);
                  n = n + 2'd1;
               end
            end
            M_FRAC: begin
               if (is_dig(c) || c == CH_UNDER) consumed = 1'b1;
               else if (c == CH_E || c == 8'h45) begin
                  mode_in = M_EXPS; consumed = 1'b1;
               end else begin
                  bun.tok[n] = mk(K_NUMBER, beg_ff, ofs_ff - beg_ff, line_ff);
                  n = n + 2'd1;
               end
            end
            M_EXPS: begin
               if (c == 8'h2B || c == CH_DASH || is_dig(c) || c == CH_UNDER) begin
                  mode_in = M_EXP; consumed = 1'b1;
               end else begin
                  bun.tok[n] = mk(K_NUMBER, beg_ff, ofs_ff - beg_ff, line_ff);
                  n = n + 2'd1;
               end
            end
            M_EXP, M_HEX, M_BIN, M_OCT: begin
               if (c == CH_UNDER
                   || (mode_ff == M_EXP && is_dig(c))
                   || (mode_ff == M_HEX && is_hexd(c))
                   || (mode_ff == M_BIN && (c == 8'h30 || c == 8'h31))
                   || (mode_ff == M_OCT && c >= 8'h30 && c <= 8'h37)) begin
                  consumed = 1'b1;
               end else begin
                  bun.tok[n] = mk(K_NUMBER, beg_ff, ofs_ff - beg_ff, line_ff);
                  n = n + 2'd1;
               end
            end
            M_MINUS: begin
               if (c == CH_EQ) begin
                  bun.tok[n] = mk(K_MINUS_EQ, beg_ff, OFS_W'(2), line_ff);
                  n = n + 2'd1;
                  mode_in = M_IDLE; consumed = 1'b1;
               end else if (c == CH_DASH) begin
                  mode_in = M_DASH2; consumed = 1'b1;
               end else begin
                  bun.tok[n] = mk(K_MINUS, beg_ff, OFS_W'(1), line_ff);
                  n = n + 2'd1;
               end
            end
            M_DASH2, M_DASHBR, M_LINECMT: begin
               // comment opener: "--[[" starts a block, anything else a line comment
               consumed = 1'b1;
               if (mode_ff == M_DASH2 && c == CH_LBRK) mode_in = M_DASHBR;
               else if (mode_ff == M_DASHBR && c == CH_LBRK) mode_in = M_BLOCK;
               else if (c == CH_NL) begin
                  bump = 1'b1; mode_in = M_IDLE;
               end else mode_in = M_LINECMT;
            end
            M_BLOCK: begin
               consumed = 1'b1;
               if (c == CH_RBRK) mode_in = M_BLOCKBR;
               else if (c == CH_NL) bump = 1'b1;
            end
            M_BLOCKBR: begin
               consumed = 1'b1;
               if (c == CH_RBRK) mode_in = M_IDLE;
               else begin
                  mode_in = M_BLOCK;
                  bump = (c == CH_NL);
               end
            end
            M_PLUS, M_SLASH, M_STAR, M_PCT, M_BANG, M_EQ, M_LESS, M_GREATER: begin
               if (c == pc2) begin
                  bun.tok[n] = mk(kd, beg_ff, OFS_W'(2), line_ff);
                  n = n + 2'd1;
                  mode_in = M_IDLE; consumed = 1'b1;
               end else if (c == CH_EQ) begin
                  bun.tok[n] = mk(ke, beg_ff, OFS_W'(2), line_ff);
                  n = n + 2'd1;
                  mode_in = M_IDLE; consumed = 1'b1;
               end else begin
                  bun.tok[n] = mk(ka, beg_ff, OFS_W'(1), line_ff);
                  n = n + 2'd1;
               end
            end
            default: consumed = 1'b0;
         endcase

         // byte not taken by the open token: start afresh
         if (!consumed) begin
            mode_in = M_IDLE;
            if (c == 8'h20 || c == 8'h0D || c == 8'h09) begin
               mode_in = M_IDLE;
            end else if (c == CH_NL) begin
               bump = 1'b1;
            end else begin
               beg_in = ofs_ff;
               if (is_let(c) || c == CH_UNDER) mode_in = M_WORD;
               else if (c == 8'h30) mode_in = M_ZERO;
               else if (is_dig(c)) mode_in = M_DEC;
               else begin
                  unique case (c)
                     CH_DASH: mode_in = M_MINUS;
                     8'h2B:   mode_in = M_PLUS;
                     8'h2F:   mode_in = M_SLASH;
                     8'h2A:   mode_in = M_STAR;
                     8'h25:   mode_in = M_PCT;
                     8'h21:   mode_in = M_BANG;
                     CH_EQ:   mode_in = M_EQ;
                     CH_LT:   mode_in = M_LESS;
                     CH_GT:   mode_in = M_GREATER;
                     8'h28:   bun.tok[n] = mk(K_LPAREN, ofs_ff, OFS_W'(1), line_ff);
                     8'h29:   bun.tok[n] = mk(K_RPAREN, ofs_ff, OFS_W'(1), line_ff);
                     8'h7B:   bun.tok[n] = mk(K_LBRACE, ofs_ff, OFS_W'(1), line_ff);
                     8'h7D:   bun.tok[n] = mk(K_RBRACE, ofs_ff, OFS_W'(1), line_ff);
                     8'h3B:   bun.tok[n] = mk(K_SEMI, ofs_ff, OFS_W'(1), line_ff);
                     8'h3A:   bun.tok[n] = mk(K_COLON, ofs_ff, OFS_W'(1), line_ff);
                     8'h2C:   bun.tok[n] = mk(K_COMMA, ofs_ff, OFS_W'(1), line_ff);
                     CH_DOT:  bun.tok[n] = mk(K_DOT, ofs_ff, OFS_W'(1), line_ff);
                     8'h26:   bun.tok[n] = mk(K_AMP, ofs_ff, OFS_W'(1), line_ff);
                     8'h7C:   bun.tok[n] = mk(K_PIPE, ofs_ff, OFS_W'(1), line_ff);
                     8'h5E:   bun.tok[n] = mk(K_CARET, ofs_ff, OFS_W'(1), line_ff);
                     8'h7E:   bun.tok[n] = mk(K_TILDE, ofs_ff, OFS_W'(1), line_ff);
                     default: bun.tok[n] = mk(K_ERROR, ofs_ff, '0, line_ff);
                  endcase
                  // every arm that is not a held punctuator gives one token
                  if (mode_in == M_IDLE) n = n + 2'd1;
               end
            end
         end

         if (ofs_ff < OFS_MAX) ofs_in = ofs_ff + OFS_W'(1);
         if (bump && line_ff < LINE_MAX) line_in = line_ff + LCW'(1);
      end
      bun.cnt = n;
   end

   assign bundle = bun;

   // Scan state advances only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         ofs_ff  <= '0;
         beg_ff  <= '0;
         dot_ff  <= '0;
         line_ff <= LCW'(1);
      end else if (accept) begin
         mode_ff <= mode_in;
         ofs_ff  <= ofs_in;
         beg_ff  <= beg_in;
         dot_ff  <= dot_in;
         line_ff <= line_in;
      end
   end

endmodule

// ===== hw/rtl/sts_out.sv =====
`timescale 1ns / 1ps

module sts_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  sts_pkg::bundle_type             bundle,
   output logic                            load_ok,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sts_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import sts_pkg::*;

   tok_type [MAX_TOK-1:0] tok_ff;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic                  take;
   tok_type               cur;

   assign rsp_tvalid = (left_ff != '0);
   assign take       = rsp_tvalid && rsp_tready;
   assign rsp_tlast  = (left_ff == CNT_W'(1));
   // a new bundle fits when no token is pending or the last pending token leaves this cycle
   assign load_ok    = (left_ff == '0) || (rsp_tlast && rsp_tready);

   assign cur       = tok_ff[pos_ff];
   assign rsp_tdata = RSP_DATA_W'(cur);

   always_comb begin
      left_in = left_ff;
      pos_in  = pos_ff;
      if (load) begin
         left_in = bundle.cnt;
         pos_in  = '0;
      end else if (take) begin
         left_in = left_ff - CNT_W'(1);
         pos_in  = pos_ff + CNT_W'(1);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         pos_ff  <= '0;
      end else begin
         left_ff <= left_in;
         pos_ff  <= pos_in;
      end
   end

   // Token payload
   always_ff @(posedge clock) begin
      if (load) tok_ff <= bundle.tok;
   end

endmodule

// ===== hw/rtl/script_token_scanner.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// req       in   req_tvalid/tready     tdata: char_byte; tuser: op (1 = end of source)
// rsp       out  rsp_tvalid/tready     tdata: kind, start, length, line; tlast: last token
//
// One byte per cycle is accepted while the token register has room; short combinational
// scan logic sits between the scan state registers and a token register that holds up to
// three tokens. The first token is valid the cycle after its byte is accepted. Tokens
// drain one per cycle while rsp_tready is high, so an item that yields several tokens
// stalls the input until its last token leaves, and longer while rsp_tready is low.
// Reset (synchronous) clears scan state: offset 0, line 1, no token pending.
// The end-of-source transaction returns the scan state to its reset values.
module script_token_scanner #(
   parameter longint unsigned MAX_SOURCE_BYTES = 64'd1048576,
   parameter longint unsigned MAX_LINES        = 64'd1048575
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] char_byte
   input  logic                            req_tuser,   // [0] op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [5:0] token_kind, [25:6] token_start, [46:26] token_length, [66:47] token_line
   output logic [sts_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import sts_pkg::*;

   logic       accept;
   logic       load_ok;
   bundle_type bundle;

   assign req_tready = load_ok;
   assign accept     = req_tvalid && load_ok;

   // Scanner state machine
   sts_core #(
      .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES),
      .MAX_LINES        (MAX_LINES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_tuser),
      .char_byte (req_tdata),
      .bundle    (bundle)
   );

   // Token register and output sequencing
   sts_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .bundle     (bundle),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
